// ----- sv/igb_pkg.sv -----
// shared types and constants of the gyro bias and scaling unit
package igb_pkg;

  localparam int AxisW     = 16;
  localparam int OutW      = 15;
  localparam int AccW      = 24;
  localparam int CountW    = 8;
  localparam int NumLanes  = 3;
  localparam int CfgIndexW = 2;
  localparam int InDataW   = 104;
  localparam int OutDataW  = 144;

  typedef enum logic [1:0] {
    MODE_FRAME,
    MODE_CAL,
    MODE_ARM,
    MODE_LOAD
  } mode_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_UPDATE,
    ACC_CLEAR
  } acc_op_e;

  typedef enum logic [1:0] {
    OFF_HOLD,
    OFF_ADD,
    OFF_LOAD
  } off_op_e;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_WOM,
    REQ_STREAM
  } req_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MOTION_MASK,
    CFG_CAL_LENGTH,
    CFG_IDLE_RELOAD
  } cfg_index_e;

  typedef struct packed {
    acc_op_e acc_op;
    logic    capture;
    logic    frame;
    logic    advance;
    off_op_e off_op;
  } lane_ctrl_t;

endpackage

// ----- sv/igb_lane.sv -----
// one axis lane: leaky bias accumulator, stored offset and output scaling
module igb_lane
  import igb_pkg::*;
#(
  parameter int AVERAGE_DIVISOR = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [AxisW-1:0]  accel_i,
  input  logic [AxisW-1:0]  rate_i,
  output logic [OutW-1:0]   out_accel_o,
  output logic [OutW-1:0]   out_rate_o,
  output logic [AxisW-1:0]  bias_o
);

  // floor(2^32 / divisor), quotient estimate is at most one low
  localparam logic [31:0]     Recip = 32'((64'd1 << 32) / AVERAGE_DIVISOR);
  localparam logic [AccW-1:0] DivW  = AccW'(AVERAGE_DIVISOR);

  logic [AccW-1:0]    acc_q, acc_d;
  logic [AxisW-1:0]   offset_q, offset_d;
  logic [OutW-1:0]    sa_accel_q, sa_rate_q;
  logic [AxisW-1:0]   sa_load_q;
  logic [OutW-1:0]    out_accel_q, out_rate_q;
  logic [AxisW-1:0]   bias_q;

  logic [AccW-1:0]    mag;
  logic [AccW+31:0]   prod;
  logic [AccW-1:0]    q0, qd, rem, quo, quot;
  logic [AxisW:0]     neg_a, adj_a, adj_r;
  logic [OutW-1:0]    scaled_a, scaled_r;

  // truncating signed division of the accumulator by the divisor
  always_comb begin
    mag  = acc_q[AccW-1] ? (~acc_q + AccW'(1)) : acc_q;
    prod = (AccW+32)'(mag) * (AccW+32)'(Recip);
    q0   = prod[AccW+31:32];
    qd   = AccW'(q0 * DivW);
    rem  = mag - qd;
    quo  = (rem >= DivW) ? (q0 + AccW'(1)) : q0;
    quot = acc_q[AccW-1] ? (~quo + AccW'(1)) : quo;
  end

  always_comb begin
    neg_a    = ~{accel_i[AxisW-1], accel_i} + (AxisW+1)'(1);
    adj_a    = neg_a + (neg_a[AxisW] ? (AxisW+1)'(3) : (AxisW+1)'(0));
    scaled_a = adj_a[AxisW:2];
    adj_r    = {rate_i[AxisW-1], rate_i} +
               (rate_i[AxisW-1] ? (AxisW+1)'(1) : (AxisW+1)'(0));
    scaled_r = adj_r[AxisW-1:1];
  end

  always_comb begin
    acc_d = acc_q;
    unique case (ctrl_i.acc_op)
      ACC_UPDATE: begin
        acc_d = acc_q + {{(AccW-AxisW){rate_i[AxisW-1]}}, rate_i} - quot;
      end
      ACC_CLEAR: acc_d = '0;
      default:   acc_d = acc_q;
    endcase
  end

  // offset changes when the request moves into the output register
  always_comb begin
    offset_d = offset_q;
    if (ctrl_i.advance) begin
      unique case (ctrl_i.off_op)
        OFF_ADD:  offset_d = offset_q + quot[AxisW-1:0];
        OFF_LOAD: offset_d = sa_load_q;
        default:  offset_d = offset_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      offset_q <= '0;
    end else begin
      if (ctrl_i.capture) begin
        acc_q <= acc_d;
      end
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sa_accel_q <= ctrl_i.frame ? scaled_a : '0;
      sa_rate_q  <= ctrl_i.frame ? scaled_r : '0;
      sa_load_q  <= rate_i;
    end
    if (ctrl_i.advance) begin
      out_accel_q <= sa_accel_q;
      out_rate_q  <= sa_rate_q;
      bias_q      <= offset_d;
    end
  end

  assign out_accel_o = out_accel_q;
  assign out_rate_o  = out_rate_q;
  assign bias_o      = bias_q;

endmodule

// ----- sv/igb_ctrl.sv -----
// configuration registers, calibration and idle counters, pipeline flow control
module igb_ctrl
  import igb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  mode_e                mode_i,
  input  logic [7:0]           status_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic                 done_o,
  output req_e                 req_o,
  output lane_ctrl_t           lane_ctrl_o
);

  logic [7:0]        mask_q, length_q, reload_q;
  logic [CountW-1:0] cal_left_q, cal_left_d, idle_left_q, idle_left_d;
  logic              av_q, ov_q;
  logic              a_done_q, a_done_d;
  req_e              a_req_q, a_req_d;
  off_op_e           a_off_q, a_off_d;
  logic              out_done_q;
  req_e              out_req_q;
  acc_op_e           acc_op;
  logic              advance, s_fire, frame;

  assign advance     = av_q && (!ov_q || m_ready_i);
  assign s_ready_o   = !av_q || advance;
  assign s_fire      = s_valid_i && s_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cal_left_d  = cal_left_q;
    idle_left_d = idle_left_q;
    a_done_d    = 1'b0;
    a_req_d     = REQ_NONE;
    a_off_d     = OFF_HOLD;
    acc_op      = ACC_HOLD;
    frame       = 1'b0;
    unique case (mode_i)
      MODE_FRAME: begin
        frame = 1'b1;
        if ((status_i & mask_q) == 8'd0) begin
          if (cal_left_q != '0) begin
            acc_op     = ACC_UPDATE;
            cal_left_d = cal_left_q - CountW'(1);
            if (cal_left_q == CountW'(1)) begin
              a_done_d = 1'b1;
              a_off_d  = OFF_ADD;
            end
          end
          if (idle_left_q != '0) begin
            idle_left_d = idle_left_q - CountW'(1);
            if (idle_left_q == CountW'(1)) begin
              a_req_d = REQ_WOM;
            end
          end
        end else begin
          idle_left_d = reload_q;
          a_req_d     = REQ_STREAM;
        end
      end
      MODE_CAL: begin
        acc_op     = ACC_CLEAR;
        cal_left_d = length_q;
      end
      MODE_ARM:  idle_left_d = reload_q;
      MODE_LOAD: a_off_d = OFF_LOAD;
      default:   frame = 1'b0;
    endcase
  end

  always_comb begin
    lane_ctrl_o.acc_op  = s_fire ? acc_op : ACC_HOLD;
    lane_ctrl_o.capture = s_fire;
    lane_ctrl_o.frame   = frame;
    lane_ctrl_o.advance = advance;
    lane_ctrl_o.off_op  = a_off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 8'd64;
      length_q    <= 8'd64;
      reload_q    <= 8'd160;
      cal_left_q  <= '0;
      idle_left_q <= '0;
      av_q        <= 1'b0;
      ov_q        <= 1'b0;
      a_done_q    <= 1'b0;
      a_req_q     <= REQ_NONE;
      a_off_q     <= OFF_HOLD;
      out_done_q  <= 1'b0;
      out_req_q   <= REQ_NONE;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_MOTION_MASK: mask_q   <= cfg_data_i;
          CFG_CAL_LENGTH:  length_q <= cfg_data_i;
          CFG_IDLE_RELOAD: reload_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_fire) begin
        cal_left_q  <= cal_left_d;
        idle_left_q <= idle_left_d;
        a_done_q    <= a_done_d;
        a_req_q     <= a_req_d;
        a_off_q     <= a_off_d;
      end
      if (s_fire) begin
        av_q <= 1'b1;
      end else if (advance) begin
        av_q <= 1'b0;
      end
      if (advance) begin
        ov_q       <= 1'b1;
        out_done_q <= a_done_q;
        out_req_q  <= a_req_q;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = ov_q;
  assign done_o    = out_done_q;
  assign req_o     = out_req_q;

  // a request held in the first stage keeps its flags while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    av_q && !advance |=> av_q && $stable(a_done_q) && $stable(a_off_q))
    else $error("stalled first stage lost its request");

  // a finished calibration always folds the accumulator into the offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    av_q && a_done_q |-> a_off_q == OFF_ADD)
    else $error("calibration done without offset update");

  // input is refused only when both stages are full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_ready_o |-> av_q && ov_q && !m_ready_i)
    else $error("input refused with room in the pipeline");

endmodule

// ----- sv/imu_gyro_bias_and_scaling_unit.sv -----
// top level of the gyro bias calibration and output scaling unit
// Takes one request per clock while the output side keeps up, and returns one
// result per request: the first stage updates the three axis accumulators
// and the calibration and idle counters, the second folds the accumulator
// into the gyro offset and loads the output register. An empty first stage
// can take a request while the output stalls, so a stalled output holds one
// result and one request in flight.
// Each axis lane divides its accumulator by AVERAGE_DIVISOR with a reciprocal
// multiply and a single correction step, so any divisor in 2 to 256 works.
// Configuration writes are always accepted and should be made while idle.
module imu_gyro_bias_and_scaling_unit
  import igb_pkg::*;
#(
  parameter int AVERAGE_DIVISOR = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // int_status, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [InDataW-1:0]   s_axis_tdata,
  // mode
  input  logic [1:0]           s_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_accel_x/y/z, out_rate_x/y/z, bias_x/y/z, calibration_done,
  // mode_request, zero padding
  output logic [OutDataW-1:0]  m_axis_tdata
);

  lane_ctrl_t       lane_ctrl;
  logic             done;
  req_e             req;
  logic [OutW-1:0]  out_accel [NumLanes];
  logic [OutW-1:0]  out_rate  [NumLanes];
  logic [AxisW-1:0] bias      [NumLanes];

  igb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .mode_i      (mode_e'(s_axis_tuser)),
    .status_i    (s_axis_tdata[7:0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .done_o      (done),
    .req_o       (req),
    .lane_ctrl_o (lane_ctrl)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    igb_lane #(
      .AVERAGE_DIVISOR (AVERAGE_DIVISOR)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl),
      .accel_i     (s_axis_tdata[8 + AxisW*g +: AxisW]),
      .rate_i      (s_axis_tdata[8 + AxisW*(NumLanes+g) +: AxisW]),
      .out_accel_o (out_accel[g]),
      .out_rate_o  (out_rate[g]),
      .bias_o      (bias[g])
    );
  end

  // merge the lane results with the shared flags into one output word
  assign m_axis_tdata = {3'b000, req, done,
                         bias[2], bias[1], bias[0],
                         out_rate[2], out_rate[1], out_rate[0],
                         out_accel[2], out_accel[1], out_accel[0]};

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the gyro bias calibration and output scaling unit
module tb;
  import igb_pkg::*;

  localparam int AvgDiv = 16;
  localparam int NumBlocks = 8;
  localparam int BlockLen = 250;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
    logic [7:0]         int_status;
  } frame_t;

  typedef struct packed {
    mode_e  mode;
    frame_t frame;
  } request_t;

  typedef struct packed {
    logic [2:0]         pad;
    req_e               mode_req;
    logic               cal_done;
    logic signed [15:0] bias_z;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_x;
    logic signed [14:0] rate_z;
    logic signed [14:0] rate_y;
    logic signed [14:0] rate_x;
    logic signed [14:0] accel_z;
    logic signed [14:0] accel_y;
    logic signed [14:0] accel_x;
  } result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  request_t cur_req = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  imu_gyro_bias_and_scaling_unit #(
    .AVERAGE_DIVISOR(AvgDiv)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (cur_req.frame),
    .s_axis_tuser (cur_req.mode),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state and register copies
  logic [7:0]         mask_cfg = 8'd64;
  logic [7:0]         cal_len_cfg = 8'd64;
  logic [7:0]         idle_cfg = 8'd160;
  logic signed [23:0] gyro_accum [3];
  logic signed [15:0] gyro_offset [3];
  logic [7:0]         cal_left = '0;
  logic [7:0]         idle_left = '0;

  request_t requests_to_send [$];
  result_t  readings_due [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_request = 1'b0;
  logic hold_spent = 1'b0;
  int  hold_left = 0;
  logic in_taken = 1'b0;

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_cal_done = 0;
  int n_wom = 0;
  int n_stream = 0;
  int n_settings = 1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [14:0] neg_quarter(logic signed [15:0] v);
    int q;
    q = -int'(v) / 4;
    return q[14:0];
  endfunction

  function automatic logic [14:0] half(logic signed [15:0] v);
    int q;
    q = int'(v) / 2;
    return q[14:0];
  endfunction

  // applies one request to the countdowns, accumulators and offsets, returns the expected result
  function automatic result_t scale_and_calibrate(request_t rq);
    result_t r;
    logic signed [15:0] rin [3];
    int a;
    r = '0;
    rin[0] = rq.frame.rate_x;
    rin[1] = rq.frame.rate_y;
    rin[2] = rq.frame.rate_z;
    case (rq.mode)
      MODE_FRAME: begin
        if ((rq.frame.int_status & mask_cfg) == 8'd0) begin
          if (cal_left != 0) begin
            for (int i = 0; i < 3; i++) begin
              a = int'(gyro_accum[i]);
              a = a + int'(rin[i]) - a / AvgDiv;
              gyro_accum[i] = a[23:0];
            end
            cal_left = cal_left - 8'd1;
            if (cal_left == 0) begin
              for (int i = 0; i < 3; i++) begin
                a = int'(gyro_offset[i]) + int'(gyro_accum[i]) / AvgDiv;
                gyro_offset[i] = a[15:0];
              end
              r.cal_done = 1'b1;
            end
          end
          if (idle_left != 0) begin
            idle_left = idle_left - 8'd1;
            if (idle_left == 0) r.mode_req = REQ_WOM;
          end
        end else begin
          idle_left = idle_cfg;
          r.mode_req = REQ_STREAM;
        end
        r.accel_x = neg_quarter(rq.frame.accel_x);
        r.accel_y = neg_quarter(rq.frame.accel_y);
        r.accel_z = neg_quarter(rq.frame.accel_z);
        r.rate_x = half(rq.frame.rate_x);
        r.rate_y = half(rq.frame.rate_y);
        r.rate_z = half(rq.frame.rate_z);
      end
      MODE_CAL: begin
        for (int i = 0; i < 3; i++) gyro_accum[i] = '0;
        cal_left = cal_len_cfg;
      end
      MODE_ARM: begin
        idle_left = idle_cfg;
      end
      default: begin
        for (int i = 0; i < 3; i++) gyro_offset[i] = rin[i];
      end
    endcase
    r.bias_x = gyro_offset[0];
    r.bias_y = gyro_offset[1];
    r.bias_z = gyro_offset[2];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] e, logic signed [31:0] g);
    if (g !== e) begin
      $error("%s: expected %0d, got %0d", name, e, g);
      errors++;
    end
  endtask

  task automatic check_result(result_t e, result_t g);
    check_field("out_accel_x", e.accel_x, g.accel_x);
    check_field("out_accel_y", e.accel_y, g.accel_y);
    check_field("out_accel_z", e.accel_z, g.accel_z);
    check_field("out_rate_x", e.rate_x, g.rate_x);
    check_field("out_rate_y", e.rate_y, g.rate_y);
    check_field("out_rate_z", e.rate_z, g.rate_z);
    check_field("bias_x", e.bias_x, g.bias_x);
    check_field("bias_y", e.bias_y, g.bias_y);
    check_field("bias_z", e.bias_z, g.bias_z);
    check_field("calibration_done", {31'd0, e.cal_done}, {31'd0, g.cal_done});
    check_field("mode_request", {30'd0, e.mode_req}, {30'd0, g.mode_req});
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req <= requests_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the pipeline up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_spent) begin
      m_axis_tready <= 1'b0;
      hold_left <= HoldCycles;
      hold_spent <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    result_t exp_r;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        readings_due.push_back(scale_and_calibrate(cur_req));
        n_requests++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (readings_due.size() == 0) begin
          $error("result arrived with nothing expected");
          errors++;
        end else begin
          exp_r = readings_due.pop_front();
          if (exp_r.cal_done) n_cal_done++;
          if (exp_r.mode_req == REQ_WOM) n_wom++;
          if (exp_r.mode_req == REQ_STREAM) n_stream++;
          check_result(exp_r, m_axis_tdata);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MOTION_MASK: mask_cfg = val;
      CFG_CAL_LENGTH:  cal_len_cfg = val;
      CFG_IDLE_RELOAD: idle_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drains everything, then lets the two pipeline stages settle
  task automatic wait_idle();
    while (requests_to_send.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic request_t build(mode_e m, logic [7:0] st,
                                     logic signed [15:0] ax, logic signed [15:0] ay,
                                     logic signed [15:0] az, logic signed [15:0] rx,
                                     logic signed [15:0] ry, logic signed [15:0] rz);
    request_t rq;
    rq.mode = m;
    rq.frame = '{rz, ry, rx, az, ay, ax, st};
    return rq;
  endfunction

  function automatic logic signed [15:0] rand_axis();
    int n;
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: begin
        n = $urandom_range(0, 8);
        n = n - 4;
        return n[15:0];
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] gyro_sample(int centre);
    int n;
    if ($urandom_range(0, 9) == 0) return rand_axis();
    n = $urandom_range(0, 128);
    n = centre + n - 64;
    return n[15:0];
  endfunction

  function automatic request_t sensor_frame(logic motion, int centre);
    logic [7:0] st;
    st = 8'($urandom);
    if (motion) begin
      if ((st & mask_cfg) == 8'd0) st = st | mask_cfg;
    end else begin
      st = st & ~mask_cfg;
    end
    return build(MODE_FRAME, st, rand_axis(), rand_axis(), rand_axis(),
                 gyro_sample(centre), gyro_sample(centre), gyro_sample(centre));
  endfunction

  function automatic request_t any_request();
    request_t rq;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    rq.mode = mode_e'($urandom_range(0, 3));
    rq.frame = bits[103:0];
    return rq;
  endfunction

  // mostly calibration and countdown runs with random content, some noise
  task automatic run_block(int count, int motion_pct);
    int made;
    int kind;
    int len;
    int centre;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        requests_to_send.push_back(build(MODE_CAL, 8'($urandom), rand_axis(), rand_axis(),
                                         rand_axis(), rand_axis(), rand_axis(), rand_axis()));
        len = int'(cal_len_cfg) + $urandom_range(0, 3);
        centre = $urandom_range(0, 4000);
        centre = centre - 2000;
        for (int i = 0; i < len; i++)
          requests_to_send.push_back(
            sensor_frame($urandom_range(0, 99) < motion_pct, centre));
        made += len + 1;
      end else if (kind < 80) begin
        requests_to_send.push_back(build(MODE_ARM, 8'($urandom), rand_axis(), rand_axis(),
                                         rand_axis(), rand_axis(), rand_axis(), rand_axis()));
        len = int'(idle_cfg) + $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
          requests_to_send.push_back(
            sensor_frame($urandom_range(0, 199) < motion_pct, 0));
        made += len + 1;
      end else if (kind < 90) begin
        requests_to_send.push_back(build(MODE_LOAD, 8'($urandom), rand_axis(), rand_axis(),
                                         rand_axis(), rand_axis(), rand_axis(), rand_axis()));
        made++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) requests_to_send.push_back(any_request());
        made += len;
      end
    end
  endtask

  initial begin
    logic [7:0] blk_mask [NumBlocks];
    logic [7:0] blk_cal [NumBlocks];
    logic [7:0] blk_idle [NumBlocks];
    int         blk_motion [NumBlocks];
    blk_mask = '{8'h40, 8'h00, 8'hFF, 8'h81, 8'h3C, 8'hFF, 8'h01, 8'hAA};
    blk_cal = '{8'd64, 8'd1, 8'd255, 8'd0, 8'd16, 8'd7, 8'd33, 8'd100};
    blk_idle = '{8'd160, 8'd1, 8'd255, 8'd0, 8'd20, 8'd40, 8'd3, 8'd255};
    blk_motion = '{10, 5, 8, 10, 3, 6, 4, 5};
    for (int i = 0; i < 3; i++) begin
      gyro_accum[i] = '0;
      gyro_offset[i] = '0;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 13;
    recv_idle_pct = 85;

    // directed: field extremes, rounding toward zero, every mode
    requests_to_send.push_back(build(MODE_FRAME, 8'h00, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    requests_to_send.push_back(build(MODE_FRAME, 8'h00, 16'sh8000, 16'sh8000, 16'sh8000,
                                     16'sh8000, 16'sh8000, 16'sh8000));
    requests_to_send.push_back(build(MODE_FRAME, 8'hBF, -16'sd1, 16'sd1, -16'sd4,
                                     -16'sd1, 16'sd1, -16'sd3));
    requests_to_send.push_back(build(MODE_FRAME, 8'h40, 16'sd3, -16'sd3, 16'sd5,
                                     16'sd3, -16'sd2, 16'sd0));
    requests_to_send.push_back(build(MODE_LOAD, 8'hFF, 16'sd100, -16'sd100, 16'sd7,
                                     16'sh7FFF, 16'sh8000, 16'sd1));
    requests_to_send.push_back(build(MODE_FRAME, 8'hFF, -16'sd5, -16'sd6, -16'sd7,
                                     16'sd5, 16'sd6, 16'sd7));
    requests_to_send.push_back(build(MODE_CAL, 8'h55, 16'sd1234, 16'sd1, 16'sd2,
                                     16'sd3, 16'sd4, 16'sd5));
    requests_to_send.push_back(build(MODE_FRAME, 8'h00, 16'sd0, 16'sd0, 16'sd0,
                                     16'sd32, -16'sd32, 16'sd17));
    requests_to_send.push_back(build(MODE_ARM, 8'hAA, -16'sd9, 16'sd9, 16'sd9,
                                     -16'sd9, 16'sd9, -16'sd9));
    requests_to_send.push_back(build(MODE_FRAME, 8'h01, 16'sd2, 16'sd2, 16'sd2,
                                     16'sd2, 16'sd2, 16'sd2));
    requests_to_send.push_back(build(MODE_LOAD, 8'h00, 16'sd0, 16'sd0, 16'sd0,
                                     16'sd0, 16'sd0, 16'sd0));
    requests_to_send.push_back(build(MODE_FRAME, 8'h40, 16'sh8000, 16'sh7FFF, 16'sd0,
                                     16'sh8000, 16'sh7FFF, -16'sd1));
    wait_idle();

    for (int b = 0; b < NumBlocks; b++) begin
      if (b == 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 13;
      end
      if (b == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end
      // an index outside the register map must change nothing
      if (b == 4) write_reg(2'd3, 8'($urandom));
      if (b > 0) begin
        write_reg(CFG_MOTION_MASK, blk_mask[b]);
        write_reg(CFG_CAL_LENGTH, blk_cal[b]);
        write_reg(CFG_IDLE_RELOAD, blk_idle[b]);
        n_settings++;
      end
      run_block(BlockLen, blk_motion[b]);
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (readings_due.size() != 0) begin
      $error("%0d results never arrived", readings_due.size());
      errors++;
    end
    $display("covered %0d requests and %0d results over %0d register settings",
             n_requests, n_results, n_settings);
    $display("calibrations finished %0d, wake-on-motion requests %0d, streaming requests %0d",
             n_cal_done, n_wom, n_stream);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/igb_pkg.sv
sv/igb_lane.sv
sv/igb_ctrl.sv
sv/imu_gyro_bias_and_scaling_unit.sv
dv/tb.sv
